/* hw/rtl/bdmc_pkg.sv */
package bdmc_pkg;

   localparam int unsigned TIME_W     = 64;
   localparam int unsigned DEBOUNCE_W = 16;
   localparam int unsigned LONG_W     = 16;
   localparam int unsigned COOL_W     = 32;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd700;
   localparam logic [COOL_W-1:0]     COOL_RESET     = 32'd60000;

   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_LONG     = 2'd1;
   localparam logic [1:0] REG_COOL     = 2'd2;

   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_MESSAGE  = 2'd1,
      ACT_CLEAR    = 2'd2,
      ACT_ANNOUNCE = 2'd3
   } action_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic [LONG_W-1:0]     long_press_ms;
      logic [COOL_W-1:0]     announce_cooldown_ms;
   } cfg_type;

endpackage

/* hw/rtl/bdmc_csr.sv */
module bdmc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bdmc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bdmc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bdmc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output bdmc_pkg::cfg_type                   cfg
);
   import bdmc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_DEBOUNCE: cfg_in.debounce_ms = pwdata[DEBOUNCE_W-1:0];
            REG_LONG:     cfg_in.long_press_ms = pwdata[LONG_W-1:0];
            REG_COOL:     cfg_in.announce_cooldown_ms = pwdata[COOL_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEBOUNCE: prdata = CSR_DATA_W'(cfg_ff.debounce_ms);
         REG_LONG:     prdata = CSR_DATA_W'(cfg_ff.long_press_ms);
         REG_COOL:     prdata = CSR_DATA_W'(cfg_ff.announce_cooldown_ms);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms          <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms        <= LONG_RESET;
         cfg_ff.announce_cooldown_ms <= COOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/bdmc_step.sv */
module bdmc_step #(
   parameter int unsigned MENU_ENTRIES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  logic                            level,
   input  logic [bdmc_pkg::TIME_W-1:0]     now,
   input  bdmc_pkg::cfg_type               cfg,
   output bdmc_pkg::action_type            action,
   output logic                            open_next,
   output logic [1:0]                      sel_next
);
   import bdmc_pkg::*;

   localparam int unsigned SEL_W = $clog2(MENU_ENTRIES);
   localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(MENU_ENTRIES - 1);
   localparam logic [SEL_W-1:0] SEL_MESSAGE  = SEL_W'(1);
   localparam logic [SEL_W-1:0] SEL_ANNOUNCE = SEL_W'(2);
   localparam logic [SEL_W-1:0] SEL_CLEAR    = SEL_W'(3);

   logic              last_raw_ff, last_raw_in;
   logic [TIME_W-1:0] lct_ff, lct_in;
   logic              stable_ff, stable_in;
   logic              armed_ff, armed_in;
   logic              used_ff, used_in;
   logic [TIME_W-1:0] press_ff, press_in;
   logic              open_ff, open_in;
   logic [SEL_W-1:0]  sel_ff, sel_in;
   logic              ann_once_ff, ann_once_in;
   logic [TIME_W-1:0] ann_time_ff, ann_time_in;

   logic [TIME_W:0] deb_sub, press_sub, ann_sub;
   logic            changed, settled, is_short, cool_ok;
   logic            do_open, do_choose, do_step;

   assign changed   = last_raw_ff != level;
   assign deb_sub   = {1'b0, now} - {1'b0, lct_ff};
   assign press_sub = {1'b0, now} - {1'b0, press_ff};
   assign ann_sub   = {1'b0, now} - {1'b0, ann_time_ff};

   assign settled  = changed ? (cfg.debounce_ms == '0)
                             : (!deb_sub[TIME_W] &&
                                deb_sub[TIME_W-1:0] >= TIME_W'(cfg.debounce_ms));
   assign is_short = press_sub[TIME_W] ||
                     (press_sub[TIME_W-1:0] < TIME_W'(cfg.long_press_ms));
   assign cool_ok  = !ann_once_ff ||
                     (!ann_sub[TIME_W] &&
                      ann_sub[TIME_W-1:0] >= TIME_W'(cfg.announce_cooldown_ms));

   // debounce and press classification
   always_comb begin
      stable_in = stable_ff;
      armed_in  = armed_ff;
      used_in   = used_ff;
      press_in  = press_ff;
      do_open   = 1'b0;
      do_choose = 1'b0;
      do_step   = 1'b0;
      if (settled) begin
         if (!level && !stable_ff) begin
            armed_in = 1'b1;
         end else if (stable_ff == level) begin
            if (armed_ff && !used_ff && !is_short) begin
               used_in   = 1'b1;
               do_open   = !open_ff;
               do_choose = open_ff;
            end
         end else begin
            stable_in = level;
            if (level) begin
               press_in = now;
               used_in  = 1'b0;
            end else if (!armed_ff) begin
               armed_in = 1'b1;
            end else if (!used_ff) begin
               do_open   = !open_ff;
               do_step   = open_ff && is_short;
               do_choose = open_ff && !is_short;
            end
         end
      end
   end

   // menu
   always_comb begin
      open_in     = open_ff;
      sel_in      = sel_ff;
      ann_once_in = ann_once_ff;
      ann_time_in = ann_time_ff;
      action      = ACT_NONE;
      if (do_open) begin
         open_in = 1'b1;
         sel_in  = '0;
      end else if (do_step) begin
         sel_in = (sel_ff == SEL_LAST) ? '0 : sel_ff + SEL_W'(1);
      end else if (do_choose) begin
         open_in = 1'b0;
         if (sel_ff == SEL_MESSAGE) begin
            action = ACT_MESSAGE;
         end else if (sel_ff == SEL_CLEAR) begin
            action = ACT_CLEAR;
         end else if (sel_ff == SEL_ANNOUNCE && cool_ok) begin
            action      = ACT_ANNOUNCE;
            ann_once_in = 1'b1;
            ann_time_in = now;
         end
      end
   end

   assign last_raw_in = level;
   assign lct_in      = changed ? now : lct_ff;
   assign open_next   = open_in;
   assign sel_next    = sel_in[1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= 1'b0;
         lct_ff      <= '0;
         stable_ff   <= 1'b0;
         armed_ff    <= 1'b0;
         used_ff     <= 1'b0;
         press_ff    <= '0;
         open_ff     <= 1'b0;
         sel_ff      <= '0;
         ann_once_ff <= 1'b0;
         ann_time_ff <= '0;
      end else if (step_en) begin
         last_raw_ff <= last_raw_in;
         lct_ff      <= lct_in;
         stable_ff   <= stable_in;
         armed_ff    <= armed_in;
         used_ff     <= used_in;
         press_ff    <= press_in;
         open_ff     <= open_in;
         sel_ff      <= sel_in;
         ann_once_ff <= ann_once_in;
         ann_time_ff <= ann_time_in;
      end
   end

endmodule

/* hw/rtl/button_debounce_menu_controller.sv */
// path: accepted item -> input register -> result register -> rsp_valid
// throughput: 1 item per cycle unless rsp_stall holds the result; all
// state updates in one pass between the input and result registers
// reset: synchronous, clears menu and debounce state and both pipeline
// valids; config registers return to 50, 700 and 60000 ms
module button_debounce_menu_controller #(
   parameter int unsigned MENU_ENTRIES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_button_level,
   input  logic [bdmc_pkg::TIME_W-1:0]         req_time_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_menu_action,
   output logic                                rsp_menu_open,
   output logic [1:0]                          rsp_selected_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bdmc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bdmc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bdmc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import bdmc_pkg::*;

   cfg_type           cfg;
   logic              in_vld_ff, in_vld_in;
   logic              in_lvl_ff;
   logic [TIME_W-1:0] in_time_ff;
   logic              out_vld_ff, out_vld_in;
   action_type        out_act_ff, step_act;
   logic              out_open_ff, step_open;
   logic [1:0]        out_sel_ff, step_sel;
   logic              out_free, move, take;

   assign out_free   = !out_vld_ff || !rsp_stall;
   assign move       = in_vld_ff && out_free;
   assign req_stall  = in_vld_ff && !out_free;
   assign take       = req_valid && !req_stall;
   assign in_vld_in  = take || (in_vld_ff && !move);
   assign out_vld_in = move || (out_vld_ff && rsp_stall);

   bdmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bdmc_step #(
      .MENU_ENTRIES (MENU_ENTRIES)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .step_en   (move),
      .level     (in_lvl_ff),
      .now       (in_time_ff),
      .cfg       (cfg),
      .action    (step_act),
      .open_next (step_open),
      .sel_next  (step_sel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (take) begin
         in_lvl_ff  <= req_button_level;
         in_time_ff <= req_time_ms;
      end
      if (move) begin
         out_act_ff  <= step_act;
         out_open_ff <= step_open;
         out_sel_ff  <= step_sel;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_menu_action   = out_act_ff;
   assign rsp_menu_open     = out_open_ff;
   assign rsp_selected_item = out_sel_ff;

endmodule

/* hw/rtl/bdmc_checker.sv */
module bdmc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [1:0]                          rsp_menu_action,
   input logic                                rsp_menu_open,
   input logic [1:0]                          rsp_selected_item
);
   import bdmc_pkg::*;

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_menu_action) &&
      $stable(rsp_menu_open) && $stable(rsp_selected_item))
      else $error("stalled result item changed");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // choosing an entry always closes the menu
   a_act_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_menu_action != ACT_NONE |-> !rsp_menu_open)
      else $error("action reported while menu open");

   // action matches the highlighted entry
   a_act_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_menu_action != ACT_NONE |->
      (rsp_menu_action == ACT_MESSAGE && rsp_selected_item == 2'd1) ||
      (rsp_menu_action == ACT_ANNOUNCE && rsp_selected_item == 2'd2) ||
      (rsp_menu_action == ACT_CLEAR && rsp_selected_item == 2'd3))
      else $error("action does not match selected entry");

   // empty pipe: the next item is never stalled
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind button_debounce_menu_controller bdmc_checker u_bdmc_checker (.*);

/* test/button_debounce_menu_controller_test.sv */
module button_debounce_menu_controller_test;
   import bdmc_pkg::*;

   localparam int unsigned MENU_SIZE = 4;
   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int unsigned ENTRY_MESSAGE = 1;
   localparam int unsigned ENTRY_ANNOUNCE = 2;
   localparam int unsigned ENTRY_CLEAR = 3;

   typedef struct {
      action_type action;
      bit         menu_open;
      bit [1:0]   sel_item;
   } menu_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_button_level = 1'b0;
   logic [TIME_W-1:0]     req_time_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_menu_action;
   logic                  rsp_menu_open;
   logic [1:0]            rsp_selected_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor copy of the controller
   bit [DEBOUNCE_W-1:0] cfg_debounce;
   bit [LONG_W-1:0]     cfg_long;
   bit [COOL_W-1:0]     cfg_cool;
   bit                  raw_level;
   bit [63:0]           raw_change_ms;
   bit                  settled_level;
   bit                  armed;
   bit                  press_consumed;
   bit [63:0]           press_begin_ms;
   bit                  menu_is_open;
   int unsigned         highlight;
   bit                  announce_done;
   bit [63:0]           announce_ms;

   menu_outcome_type pending_outcomes[$];
   bit [63:0]   now_ms;
   int unsigned sender_idle_pct = 17;
   int unsigned receiver_stall_pct = 63;
   int unsigned stall_hold_cycles = 0;
   int unsigned polls_sent = 0;
   int unsigned results_seen = 0;
   int unsigned csr_writes = 0;
   int unsigned error_count = 0;
   int unsigned actions_seen[4];

   button_debounce_menu_controller #(.MENU_ENTRIES(MENU_SIZE)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_button_level(req_button_level),
      .req_time_ms(req_time_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_menu_action(rsp_menu_action),
      .rsp_menu_open(rsp_menu_open),
      .rsp_selected_item(rsp_selected_item),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d items still pending", pending_outcomes.size());
      $display("button_debounce_menu_controller_test failed");
      $finish;
   end

   task report_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   function automatic bit press_is_short(bit [63:0] now);
      return now < press_begin_ms || now - press_begin_ms < cfg_long;
   endfunction

   function automatic action_type pick_entry(bit [63:0] now);
      menu_is_open = 1'b0;
      case (highlight)
         ENTRY_MESSAGE: return ACT_MESSAGE;
         ENTRY_CLEAR: return ACT_CLEAR;
         ENTRY_ANNOUNCE: begin
            if (!announce_done || (now >= announce_ms && now - announce_ms >= cfg_cool)) begin
               announce_done = 1'b1;
               announce_ms = now;
               return ACT_ANNOUNCE;
            end
         end
         default: ;
      endcase
      return ACT_NONE;
   endfunction

   function automatic action_type predict_poll(bit level, bit [63:0] now);
      if (raw_level != level) begin
         raw_level = level;
         raw_change_ms = now;
      end
      if (now < raw_change_ms || now - raw_change_ms < cfg_debounce) return ACT_NONE;
      if (!level && !settled_level) begin
         armed = 1'b1;
         return ACT_NONE;
      end
      if (settled_level == level) begin
         // steady press: a long hold acts once
         if (!armed || press_consumed || press_is_short(now)) return ACT_NONE;
         press_consumed = 1'b1;
         if (!menu_is_open) begin
            menu_is_open = 1'b1;
            highlight = 0;
            return ACT_NONE;
         end
         return pick_entry(now);
      end
      settled_level = level;
      if (level) begin
         press_begin_ms = now;
         press_consumed = 1'b0;
         return ACT_NONE;
      end
      if (!armed) begin
         armed = 1'b1;
         return ACT_NONE;
      end
      if (press_consumed) return ACT_NONE;
      if (!menu_is_open) begin
         menu_is_open = 1'b1;
         highlight = 0;
         return ACT_NONE;
      end
      if (press_is_short(now)) begin
         highlight = (highlight + 1) % MENU_SIZE;
         return ACT_NONE;
      end
      return pick_entry(now);
   endfunction

   function automatic bit [31:0] reg_value(logic [1:0] index);
      case (index)
         REG_DEBOUNCE: return {16'd0, cfg_debounce};
         REG_LONG: return {16'd0, cfg_long};
         REG_COOL: return cfg_cool;
         default: return '0;
      endcase
   endfunction

   task send_poll(input bit level, input bit [63:0] stamp);
      menu_outcome_type want;
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_button_level <= level;
      req_time_ms <= stamp;
      do @(posedge clock); while (req_stall !== 1'b0);
      want.action = predict_poll(level, stamp);
      want.menu_open = menu_is_open;
      want.sel_item = highlight[1:0];
      pending_outcomes.push_back(want);
      polls_sent++;
   endtask

   task settle_block();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(input logic [1:0] index, input bit [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_DEBOUNCE: cfg_debounce = value[DEBOUNCE_W-1:0];
         REG_LONG: cfg_long = value[LONG_W-1:0];
         REG_COOL: cfg_cool = value[COOL_W-1:0];
         default: ;
      endcase
      csr_writes++;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task check_reg(input logic [1:0] index);
      bit [31:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      if (got !== reg_value(index))
         report_error($sformatf("register %0d: expected %0h, got %0h", index,
                                reg_value(index), got));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task click(input bit [63:0] held);
      send_poll(1'b1, now_ms);
      now_ms += held;
      send_poll(1'b0, now_ms);
      now_ms += 1;
   endtask

   task chatter(input bit settle_to);
      int unsigned n;
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         send_poll(i[0] ? !settle_to : settle_to, now_ms);
         now_ms += $urandom_range(0, cfg_debounce / 2);
      end
   endtask

   task hold_level(input bit level, input int unsigned span);
      bit [63:0] stop;
      int unsigned stride;
      stop = now_ms + cfg_debounce + span;
      stride = (cfg_debounce + span) / 3 + 1;
      send_poll(level, now_ms);
      while (now_ms < stop) begin
         now_ms += $urandom_range(1, stride);
         send_poll(level, now_ms);
      end
   endtask

   task press_button(input bit held_long);
      int unsigned span;
      if (held_long) span = cfg_long + $urandom_range(0, cfg_long);
      else span = (cfg_long == 0) ? 0 : $urandom_range(0, cfg_long - 1);
      chatter(1'b1);
      hold_level(1'b1, span);
      chatter(1'b0);
      hold_level(1'b0, $urandom_range(0, cfg_long));
   endtask

   task poll_noise();
      int unsigned pick;
      repeat ($urandom_range(1, 3)) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_poll(1'($urandom_range(1)), now_ms - $urandom_range(0, cfg_debounce + 20));
         end else if (pick < 93) begin
            now_ms += $urandom_range(0, cfg_debounce + 20);
            send_poll(1'($urandom_range(1)), now_ms);
         end else begin
            send_poll(1'($urandom_range(1)), {$urandom, $urandom});
         end
      end
   endtask

   task run_poll_traffic(input int unsigned polls);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = polls_sent + polls;
      while (polls_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 85) press_button(pick < 35);
         else poll_noise();
      end
   endtask

   task test_register_access();
      check_reg(REG_DEBOUNCE);
      check_reg(REG_LONG);
      check_reg(REG_COOL);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      check_reg(REG_DEBOUNCE);
      check_reg(REG_LONG);
      check_reg(REG_COOL);
   endtask

   task test_startup_hold();
      send_poll(1'b1, 64'd0);
      send_poll(1'b1, 64'd100);
      send_poll(1'b1, 64'd2000);
      send_poll(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_poll(1'b0, 64'd10);
      send_poll(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
      send_poll(1'b0, 64'h5555_5555_5555_5555);
      send_poll(1'b0, 64'h5555_5555_5555_55B9);
      now_ms = 64'h5555_5555_5555_5600;
   endtask

   task test_menu_walk();
      settle_block();
      // upper bits must be dropped
      write_reg(REG_DEBOUNCE, 32'hFFFF_0000);
      write_reg(REG_LONG, 32'h0001_000A);
      write_reg(REG_COOL, 32'd100);
      check_reg(REG_DEBOUNCE);
      check_reg(REG_LONG);
      click(1);
      send_poll(1'b1, now_ms);
      now_ms += 15;
      send_poll(1'b1, now_ms);
      now_ms += 1;
      send_poll(1'b0, now_ms);
      now_ms += 1;
      click(1);
      click(1);
      click(1);
      click(20);
   endtask

   task test_random_slow_receiver();
      settle_block();
      write_reg(REG_DEBOUNCE, $urandom_range(1, 20));
      write_reg(REG_LONG, $urandom_range(20, 120));
      write_reg(REG_COOL, $urandom_range(50, 400));
      sender_idle_pct = 17;
      receiver_stall_pct = 63;
      run_poll_traffic(600);
   endtask

   task test_random_slow_sender();
      settle_block();
      write_reg(REG_DEBOUNCE, 32'h0000_FFFF);
      write_reg(REG_LONG, 32'h0000_FFFF);
      write_reg(REG_COOL, 32'hFFFF_FFFF);
      check_reg(REG_COOL);
      sender_idle_pct = 63;
      receiver_stall_pct = 17;
      now_ms += {$urandom_range(1, 32'h00FF_FFFF), $urandom};
      run_poll_traffic(350);
   endtask

   task test_random_zero_settings();
      settle_block();
      write_reg(REG_DEBOUNCE, 32'd0);
      write_reg(REG_LONG, 32'd0);
      write_reg(REG_COOL, 32'd0);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      run_poll_traffic(150);
   endtask

   task test_backpressure();
      settle_block();
      write_reg(REG_DEBOUNCE, $urandom_range(0, 10));
      write_reg(REG_LONG, $urandom_range(10, 60));
      write_reg(REG_COOL, $urandom_range(0, 300));
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      stall_hold_cycles = 80;
      run_poll_traffic(40);
      run_poll_traffic(480);
   endtask

   always @(posedge clock) begin
      if (stall_hold_cycles > 0) begin
         stall_hold_cycles = stall_hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      menu_outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            report_error($sformatf("unexpected item: action %0d open %0b sel %0d",
                                   rsp_menu_action, rsp_menu_open, rsp_selected_item));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_menu_action !== want.action || rsp_menu_open !== want.menu_open ||
                rsp_selected_item !== want.sel_item) begin
               report_error($sformatf(
                  "item %0d: expected action %s open %0b sel %0d, got action %0d open %0b sel %0d",
                  results_seen, want.action.name(), want.menu_open, want.sel_item,
                  rsp_menu_action, rsp_menu_open, rsp_selected_item));
            end else begin
               actions_seen[want.action]++;
            end
         end
      end
   end

   initial begin
      cfg_debounce = DEBOUNCE_RESET;
      cfg_long = LONG_RESET;
      cfg_cool = COOL_RESET;
      now_ms = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_startup_hold();
      test_menu_walk();
      test_random_slow_receiver();
      test_random_slow_sender();
      test_random_zero_settings();
      test_backpressure();
      settle_block();
      repeat (8) @(posedge clock);
      $display("%0d polls and %0d results checked under four traffic patterns, %0d csr writes",
               polls_sent, results_seen, csr_writes);
      $display("menu actions seen: %0d message, %0d clear, %0d announce",
               actions_seen[ACT_MESSAGE], actions_seen[ACT_CLEAR], actions_seen[ACT_ANNOUNCE]);
      if (error_count == 0) begin
         $display("button_debounce_menu_controller_test passed");
      end else begin
         $display("%0d errors", error_count);
         $display("button_debounce_menu_controller_test failed");
      end
      $finish;
   end

endmodule
